/* sv/i2c_sensor_read_sequencer_defines.svh */
// assertion macros used by the step core of the sensor read sequencer rtl
`ifndef I2C_SENSOR_READ_SEQUENCER_DEFINES_SVH
`define I2C_SENSOR_READ_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define I2CSRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2csrs same-cycle check failed");

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define I2CSRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2csrs next-cycle check failed");

`endif

/* sv/i2csrs_pkg.sv */
// shared types and codes for the i2c sensor read sequencer
package i2csrs_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CIDX_W  = 2;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_START = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CMDW  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CMDR  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_MSB   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_LSB   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd6;

  // controller event codes
  localparam logic [FUNC_W-1:0] EV_START = 3'd0;
  localparam logic [FUNC_W-1:0] EV_ACK   = 3'd1;
  localparam logic [FUNC_W-1:0] EV_NACK  = 3'd2;
  localparam logic [FUNC_W-1:0] EV_RX    = 3'd3;
  localparam logic [FUNC_W-1:0] EV_STOP  = 3'd4;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SENSOR_ADDR = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CMD_BYTE    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DONE_CODE   = 2'd2;

  // configuration reset values
  localparam logic [ADDR_W-1:0] SENSOR_ADDR_RST = 7'd64;
  localparam logic [BYTE_W-1:0] CMD_BYTE_RST    = 8'd0;
  localparam logic [BYTE_W-1:0] DONE_CODE_RST   = 8'd0;

  // i2c direction bit
  localparam logic DIR_WRITE = 1'b0;
  localparam logic DIR_READ  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] sensor_addr;
    logic [BYTE_W-1:0] cmd_byte;
    logic [BYTE_W-1:0] done_code;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic               issue_start;
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               issue_ack;
    logic               issue_nack_stop;
    logic               done_res;
    logic [BYTE_W-1:0]  event_code;
    logic [WORD_W-1:0]  measurement;
    logic               protocol_error;
    logic [PHASE_W-1:0] phase;
  } res_t;

endpackage

/* sv/i2csrs_cfg_regs.sv */
// configuration register file of the sequencer
module i2csrs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [i2csrs_pkg::CIDX_W-1:0] wr_index,
  input  logic [i2csrs_pkg::BYTE_W-1:0] wr_data,
  output i2csrs_pkg::cfg_t            cfg
);
  import i2csrs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_SENSOR_ADDR: cfg_nxt.sensor_addr = wr_data[ADDR_W-1:0];
        CFG_CMD_BYTE:    cfg_nxt.cmd_byte    = wr_data;
        CFG_DONE_CODE:   cfg_nxt.done_code   = wr_data;
        default:         cfg_nxt = cfg_r; // unused index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_addr <= SENSOR_ADDR_RST;
      cfg_r.cmd_byte    <= CMD_BYTE_RST;
      cfg_r.done_code   <= DONE_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/i2csrs_core.sv */
// phase state, result word and per-event step logic
module i2csrs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  i2csrs_pkg::item_t item,
  input  i2csrs_pkg::cfg_t  cfg,
  output i2csrs_pkg::res_t  res
);
  import i2csrs_pkg::*;

  `include "i2c_sensor_read_sequencer_defines.svh"

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [WORD_W-1:0]  word_r;
  logic [WORD_W-1:0]  word_nxt;
  logic [BYTE_W-1:0]  addr_wr;
  logic [BYTE_W-1:0]  addr_rd;

  assign addr_wr = {cfg.sensor_addr, DIR_WRITE};
  assign addr_rd = {cfg.sensor_addr, DIR_READ};

  always_comb begin
    phase_nxt = phase_r;
    word_nxt  = word_r;
    res       = '0;
    case (item.func)
      EV_START: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt       = PH_START;
          word_nxt        = '0;
          res.issue_start = 1'b1;
          res.tx_valid    = 1'b1;
          res.tx_byte     = addr_wr;
        end else begin
          res.protocol_error = 1'b1;
        end
      end
      EV_ACK: begin
        case (phase_r)
          PH_START: begin
            phase_nxt    = PH_CMDW;
            res.tx_valid = 1'b1;
            res.tx_byte  = cfg.cmd_byte;
          end
          PH_CMDW: begin
            phase_nxt       = PH_CMDR;
            res.issue_start = 1'b1;
            res.tx_valid    = 1'b1;
            res.tx_byte     = addr_rd;
          end
          PH_CMDR: phase_nxt = PH_MSB;
          PH_MSB:  phase_nxt = PH_LSB;
          default: res.protocol_error = 1'b1;
        endcase
      end
      EV_NACK: begin
        // sensor still converting: poll with another read-address start
        if (phase_r == PH_CMDR) begin
          res.issue_start = 1'b1;
          res.tx_valid    = 1'b1;
          res.tx_byte     = addr_rd;
        end else begin
          res.protocol_error = 1'b1;
        end
      end
      EV_RX: begin
        if (phase_r == PH_MSB) begin
          word_nxt      = {word_r[BYTE_W-1:0], item.rx_byte};
          phase_nxt     = PH_LSB;
          res.issue_ack = 1'b1;
        end else if (phase_r == PH_LSB) begin
          word_nxt            = {word_r[BYTE_W-1:0], item.rx_byte};
          phase_nxt           = PH_DONE;
          res.issue_nack_stop = 1'b1;
        end else begin
          res.protocol_error = 1'b1;
        end
      end
      EV_STOP: begin
        if (phase_r == PH_DONE) begin
          phase_nxt       = PH_IDLE;
          res.done_res    = 1'b1;
          res.event_code  = cfg.done_code;
          res.measurement = word_r;
        end else begin
          res.protocol_error = 1'b1;
        end
      end
      default: res.protocol_error = 1'b1;
    endcase
    res.phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      word_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      word_r  <= word_nxt;
    end
  end

  `I2CSRS_ASSERT_NOW(a_err_holds_phase, fire && res.protocol_error, phase_nxt == phase_r)
  `I2CSRS_ASSERT_NOW(a_done_from_done, fire && res.done_res, phase_r == PH_DONE)
  `I2CSRS_ASSERT_NEXT(a_ack_to_lsb, fire && res.issue_ack, phase_r == PH_LSB)
  `I2CSRS_ASSERT_NEXT(a_nstop_to_done, fire && res.issue_nack_stop, phase_r == PH_DONE)

endmodule

/* sv/i2c_sensor_read_sequencer.sv */
// top level of the i2c sensor read sequencer: input stage, step core, result stage
// a beat in the input stage steps the core once the result stage has room; its result is registered there for out_*
// throughput: one event beat per cycle while out_ready stays high; a result stall holds the input stage
// the phase/result state updates as an item leaves the input stage, in order
// reset (rst_n low, synchronous): phase idle, result word zero, stages empty,
// device address 64, command byte 0, done event code 0
module i2c_sensor_read_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  // event channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [i2csrs_pkg::FUNC_W-1:0] in_func,
  input  logic [i2csrs_pkg::BYTE_W-1:0] in_rx_byte,
  // command / result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_issue_start,
  output logic                          out_tx_valid,
  output logic [i2csrs_pkg::BYTE_W-1:0] out_tx_byte,
  output logic                          out_issue_ack,
  output logic                          out_issue_nack_stop,
  output logic                          out_done_res,
  output logic [i2csrs_pkg::BYTE_W-1:0] out_event_code,
  output logic [i2csrs_pkg::WORD_W-1:0] out_measurement,
  output logic                          out_protocol_error,
  output logic [i2csrs_pkg::PHASE_W-1:0] out_phase,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [i2csrs_pkg::CIDX_W-1:0] cfg_index,
  input  logic [i2csrs_pkg::BYTE_W-1:0] cfg_data
);
  import i2csrs_pkg::*;

  // input stage: holds one event beat until the core can step on it
  logic  in_vld_r;
  item_t in_item_r;

  // result stage: holds one result beat until the consumer takes it
  logic  out_vld_r;
  res_t  out_res_r;

  cfg_t  cfg;
  res_t  step_res;

  // core steps when the input stage is full and the result stage has room
  logic  step_fire;
  logic  in_take;

  assign step_fire = in_vld_r && (!out_vld_r || out_ready);
  // input stage frees up in the same cycle its beat moves on
  assign in_ready  = !in_vld_r || step_fire;
  assign in_take   = in_valid && in_ready;

  // config writes always taken; the user issues them only while idle, unchecked
  assign cfg_ready = 1'b1;

  i2csrs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  i2csrs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (step_fire),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  // input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // input stage payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.func    <= in_func;
      in_item_r.rx_byte <= in_rx_byte;
    end
  end

  // result stage valid: filled on a step, drained by the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_issue_start     = out_res_r.issue_start;
  assign out_tx_valid        = out_res_r.tx_valid;
  assign out_tx_byte         = out_res_r.tx_byte;
  assign out_issue_ack       = out_res_r.issue_ack;
  assign out_issue_nack_stop = out_res_r.issue_nack_stop;
  assign out_done_res        = out_res_r.done_res;
  assign out_event_code      = out_res_r.event_code;
  assign out_measurement     = out_res_r.measurement;
  assign out_protocol_error  = out_res_r.protocol_error;
  assign out_phase           = out_res_r.phase;

endmodule

/* tb/i2c_sensor_read_sequencer_tb.sv */
// testbench for the i2c sensor read sequencer: event beats checked by a scoreboard
module i2c_sensor_read_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2csrs_pkg::*;

  // cycles with no beat on any channel before the run is abandoned
  localparam int unsigned QUIET_LIMIT = 1000;
  // random event beats per configuration phase, and the number of phases
  localparam int unsigned PHASE_BEATS = 300;
  localparam int unsigned NUM_PHASES  = 6;

  // tracks the sequencer's phase, the assembled word and the register copies,
  // and holds the controller commands still owed by the block
  class read_seq_scoreboard;
    logic [ADDR_W-1:0]  sensor_addr;
    logic [BYTE_W-1:0]  cmd_byte;
    logic [BYTE_W-1:0]  done_code;
    logic [PHASE_W-1:0] seq_phase;
    logic [WORD_W-1:0]  word;
    res_t               owed_cmds[$];
    int unsigned        mismatches;

    function new();
      sensor_addr = SENSOR_ADDR_RST;
      cmd_byte    = CMD_BYTE_RST;
      done_code   = DONE_CODE_RST;
      seq_phase   = PH_IDLE;
      word        = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      case (idx)
        CFG_SENSOR_ADDR: sensor_addr = data[ADDR_W-1:0];
        CFG_CMD_BYTE:    cmd_byte    = data;
        CFG_DONE_CODE:   done_code   = data;
        default: ;
      endcase
    endfunction

    // one event beat accepted: step the phase and queue the commands it causes
    function void take_event(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b);
      res_t r;
      r = '0;
      case (f)
        EV_START: begin
          if (seq_phase == PH_IDLE) begin
            seq_phase     = PH_START;
            word          = '0;
            r.issue_start = 1'b1;
            r.tx_valid    = 1'b1;
            r.tx_byte     = {sensor_addr, DIR_WRITE};
          end else begin
            r.protocol_error = 1'b1;
          end
        end
        EV_ACK: begin
          case (seq_phase)
            PH_START: begin
              seq_phase  = PH_CMDW;
              r.tx_valid = 1'b1;
              r.tx_byte  = cmd_byte;
            end
            PH_CMDW: begin
              seq_phase     = PH_CMDR;
              r.issue_start = 1'b1;
              r.tx_valid    = 1'b1;
              r.tx_byte     = {sensor_addr, DIR_READ};
            end
            PH_CMDR: seq_phase = PH_MSB;
            PH_MSB:  seq_phase = PH_LSB;
            default: r.protocol_error = 1'b1;
          endcase
        end
        EV_NACK: begin
          if (seq_phase == PH_CMDR) begin
            r.issue_start = 1'b1;
            r.tx_valid    = 1'b1;
            r.tx_byte     = {sensor_addr, DIR_READ};
          end else begin
            r.protocol_error = 1'b1;
          end
        end
        EV_RX: begin
          if (seq_phase == PH_MSB || seq_phase == PH_LSB) begin
            word = {word[BYTE_W-1:0], b};
            if (seq_phase == PH_MSB) begin
              seq_phase   = PH_LSB;
              r.issue_ack = 1'b1;
            end else begin
              seq_phase         = PH_DONE;
              r.issue_nack_stop = 1'b1;
            end
          end else begin
            r.protocol_error = 1'b1;
          end
        end
        EV_STOP: begin
          if (seq_phase == PH_DONE) begin
            seq_phase     = PH_IDLE;
            r.done_res    = 1'b1;
            r.event_code  = done_code;
            r.measurement = word;
          end else begin
            r.protocol_error = 1'b1;
          end
        end
        default: r.protocol_error = 1'b1;
      endcase
      r.phase = seq_phase;
      owed_cmds.push_back(r);
    endfunction

    function void check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_commands(res_t seen);
      res_t want;
      if (owed_cmds.size() == 0) begin
        $error("result beat with no event waiting");
        mismatches++;
        return;
      end
      want = owed_cmds.pop_front();
      check_field("issue_start", WORD_W'(want.issue_start), WORD_W'(seen.issue_start));
      check_field("tx_valid", WORD_W'(want.tx_valid), WORD_W'(seen.tx_valid));
      check_field("tx_byte", WORD_W'(want.tx_byte), WORD_W'(seen.tx_byte));
      check_field("issue_ack", WORD_W'(want.issue_ack), WORD_W'(seen.issue_ack));
      check_field("issue_nack_stop", WORD_W'(want.issue_nack_stop),
                  WORD_W'(seen.issue_nack_stop));
      check_field("done_res", WORD_W'(want.done_res), WORD_W'(seen.done_res));
      check_field("event_code", WORD_W'(want.event_code), WORD_W'(seen.event_code));
      check_field("measurement", want.measurement, seen.measurement);
      check_field("protocol_error", WORD_W'(want.protocol_error),
                  WORD_W'(seen.protocol_error));
      check_field("phase", WORD_W'(want.phase), WORD_W'(seen.phase));
    endfunction

    function int unsigned pending();
      return owed_cmds.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func;
  logic [BYTE_W-1:0]   in_rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic                out_issue_start;
  logic                out_tx_valid;
  logic [BYTE_W-1:0]   out_tx_byte;
  logic                out_issue_ack;
  logic                out_issue_nack_stop;
  logic                out_done_res;
  logic [BYTE_W-1:0]   out_event_code;
  logic [WORD_W-1:0]   out_measurement;
  logic                out_protocol_error;
  logic [PHASE_W-1:0]  out_phase;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index;
  logic [BYTE_W-1:0]   cfg_data;

  // random gaps on the event side and stalls on the result side
  logic                idle_on;
  logic                stall_on;
  int unsigned         quiet_cycles = 0;

  read_seq_scoreboard  sb;

  i2c_sensor_read_sequencer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_issue_start     (out_issue_start),
    .out_tx_valid        (out_tx_valid),
    .out_tx_byte         (out_tx_byte),
    .out_issue_ack       (out_issue_ack),
    .out_issue_nack_stop (out_issue_nack_stop),
    .out_done_res        (out_done_res),
    .out_event_code      (out_event_code),
    .out_measurement     (out_measurement),
    .out_protocol_error  (out_protocol_error),
    .out_phase           (out_phase),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // present one event beat from a falling edge, hold it until taken, and
  // hand it to the scoreboard on the edge that takes it; returns on a falling
  // edge with in_valid still high so back-to-back beats need no re-raise
  task automatic push_event(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 11);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_func    = f;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_event(f, b);
    @(negedge clk);
  endtask

  // one register write beat; the caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // drop the event channel and let every owed result drain, then let the
  // two-stage pipeline settle before touching the registers
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly the event a healthy controller would raise in the current phase,
  // sometimes any code at all (unknown codes included) to break sequences
  function automatic item_t pick_event();
    item_t ev;
    ev.rx_byte = BYTE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 12) begin
      ev.func = FUNC_W'($urandom_range(0, 7));
    end else begin
      case (sb.seq_phase)
        PH_IDLE:           ev.func = EV_START;
        PH_START, PH_CMDW: ev.func = EV_ACK;
        // sensor still converting: poll the read address a few times
        PH_CMDR:           ev.func = ($urandom_range(0, 2) == 0) ? EV_NACK : EV_ACK;
        // an ack interrupt in the msb phase skips straight to the lsb
        PH_MSB:            ev.func = ($urandom_range(0, 7) == 0) ? EV_ACK : EV_RX;
        PH_LSB:            ev.func = EV_RX;
        default:           ev.func = EV_STOP;
      endcase
    end
    return ev;
  endfunction

  // result side: random stall bursts while stall_on, otherwise always ready
  initial begin : ready_gen
    int unsigned n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 11);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // result monitor: values seen at the rising edge are those before it
  always @(posedge clk) begin : result_mon
    res_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.issue_start     = out_issue_start;
      seen.tx_valid        = out_tx_valid;
      seen.tx_byte         = out_tx_byte;
      seen.issue_ack       = out_issue_ack;
      seen.issue_nack_stop = out_issue_nack_stop;
      seen.done_res        = out_done_res;
      seen.event_code      = out_event_code;
      seen.measurement     = out_measurement;
      seen.protocol_error  = out_protocol_error;
      seen.phase           = out_phase;
      sb.check_commands(seen);
    end
  end

  // watchdog: too long without a beat on any channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("i2c_sensor_read_sequencer_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    item_t ev;
    sb         = new();
    in_valid   = 1'b0;
    in_func    = EV_START;
    in_rx_byte = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_SENSOR_ADDR;
    cfg_data   = '0;
    idle_on    = 1'b1;
    stall_on   = 1'b1;
    rst_n      = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed part, on the reset register values
    // events that make no sense in idle
    push_event(EV_ACK, 8'h00);
    push_event(EV_STOP, 8'h00);
    push_event(EV_RX, 8'hFF);
    push_event(EV_NACK, 8'h00);
    // unknown event codes
    push_event(3'd5, 8'h5A);
    push_event(3'd6, 8'hA5);
    push_event(3'd7, 8'hFF);
    // full read with read-address polling and stray events along the way
    push_event(EV_START, 8'h00);
    push_event(EV_START, 8'h00);   // start while busy
    push_event(EV_NACK, 8'h00);    // nack on the write address
    push_event(EV_ACK, 8'h00);
    push_event(EV_ACK, 8'h00);
    push_event(EV_NACK, 8'h00);    // conversion still running
    push_event(EV_NACK, 8'h00);
    push_event(EV_ACK, 8'h00);
    push_event(EV_STOP, 8'h00);    // stop before any byte
    push_event(EV_RX, 8'hFF);
    push_event(EV_RX, 8'h00);
    push_event(EV_ACK, 8'h00);     // ack once the stop is under way
    push_event(EV_STOP, 8'h00);
    // second read: word cleared at start, ack in the msb phase skips to lsb
    push_event(EV_START, 8'h00);
    push_event(EV_ACK, 8'h00);
    push_event(EV_ACK, 8'h00);
    push_event(EV_ACK, 8'h00);
    push_event(EV_ACK, 8'h00);
    push_event(EV_RX, 8'hA5);
    push_event(EV_STOP, 8'h00);

    // random part: registers rewritten between phases, extremes first
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          // address byte with the top bit set, which the block must drop
          write_reg(CFG_SENSOR_ADDR, 8'hFF);
          write_reg(CFG_CMD_BYTE, 8'hFF);
          write_reg(CFG_DONE_CODE, 8'hFF);
        end
        1: begin
          write_reg(CFG_DONE_CODE, 8'h00);
          write_reg(CFG_CMD_BYTE, 8'h00);
          write_reg(CFG_SENSOR_ADDR, 8'h00);
        end
        default: begin
          write_reg(CFG_SENSOR_ADDR, BYTE_W'($urandom_range(0, 255)));
          write_reg(CFG_CMD_BYTE, BYTE_W'($urandom_range(0, 255)));
          write_reg(CFG_DONE_CODE, BYTE_W'($urandom_range(0, 255)));
        end
      endcase
      // the unused index must leave every register alone
      write_reg(2'd3, BYTE_W'($urandom_range(0, 255)));
      cfg_valid = 1'b0;
      // no idling and no result stalls in the last phase
      idle_on  = (p < NUM_PHASES - 1);
      stall_on = (p < NUM_PHASES - 1);
      repeat (PHASE_BEATS) begin
        ev = pick_event();
        push_event(ev.func, ev.rx_byte);
      end
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("i2c_sensor_read_sequencer_tb passed");
    end else begin
      $display("i2c_sensor_read_sequencer_tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/i2csrs_pkg.sv
sv/i2csrs_cfg_regs.sv
sv/i2csrs_core.sv
sv/i2c_sensor_read_sequencer.sv
tb/i2c_sensor_read_sequencer_tb.sv
